// ----- design/stq_pkg.sv -----
`default_nettype none

package stq_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int ID_W = 5;
   localparam int WORD_W = 32;
   localparam int NUM_IDS = 2 ** ID_W;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED       = 3'd0,
      ST_FULL        = 3'd1,
      ST_PENDING     = 3'd2,
      ST_DELETED     = 3'd3,
      ST_NOT_PENDING = 3'd4,
      ST_FIRED       = 3'd5,
      ST_NOTHING     = 3'd6
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [ID_W-1:0]     timer_id;
      logic [WORD_W-1:0]   expiry_time;
      logic [WORD_W-1:0]   payload;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     fired_id;
      logic [WORD_W-1:0]   fired_payload;
      logic [WORD_W-1:0]   current_tick;
      logic                last;
   } rsp_type;

   // logical queue position used for the read port
   typedef enum logic [2:0] {
      RA_ZERO    = 3'd0,
      RA_ONE     = 3'd1,
      RA_LAST    = 3'd2,
      RA_IDX_DEC = 3'd3,
      RA_IDX_INC = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_ZERO    = 2'd0,
      WA_IDX_INC = 2'd1,
      WA_IDX_DEC = 2'd2
   } wr_loc_type;

   typedef enum logic [2:0] {
      IDX_HOLD = 3'd0,
      IDX_ZERO = 3'd1,
      IDX_LAST = 3'd2,
      IDX_DEC  = 3'd3,
      IDX_INC  = 3'd4
   } idx_op_type;

   typedef struct packed {
      logic        latch_req;
      logic        tick_inc;
      rd_sel_type  rd_sel;
      idx_op_type  idx_op;
      logic        wr_en;
      logic        wr_new;       // write the request entry, else the read entry
      wr_loc_type  wr_loc;
      logic        count_inc;
      logic        count_dec;
      logic        pop;          // drop the head entry
      logic        pending_set;
      logic        pending_clr;
      logic        hold_load;
      logic        rsp_load;
      logic        rsp_fired;
      status_type  rsp_status;
      logic        rsp_last;
   } cmd_type;

   typedef struct packed {
      op_type  op;
      logic    full;
      logic    empty;
      logic    id_pending;
      logic    rd_less;      // read entry expires before the new one
      logic    rd_due;       // read entry expires at or before the tick count
      logic    rd_id_match;
      logic    idx_zero;
      logic    idx_last;
      logic    out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/stq_chan_if.sv -----
`default_nettype none

interface stq_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/stq_ctrl.sv -----
`default_nettype none

module stq_ctrl
   import stq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire stat_type stat,
   output logic          idle,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ADD_CMP,
      S_ADD_LAST,
      S_DEL_SCAN,
      S_TICK_CHK,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       found_ff, found_in;
   logic       hold_valid_ff, hold_valid_in;
   logic       due;

   assign idle = (state_ff == S_IDLE);
   assign due  = !stat.empty && stat.rd_due;

   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = RA_ZERO;
      cmd.idx_op    = IDX_HOLD;
      cmd.wr_loc    = WA_ZERO;
      cmd.rsp_status = ST_ADDED;
      state_in      = state_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      hold_valid_in = hold_valid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.latch_req = 1'b1;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            case (stat.op)
               OP_ADD: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                     state_in = S_RESP;
                  end else if (stat.id_pending) begin
                     status_in = ST_PENDING;
                     state_in = S_RESP;
                  end else if (stat.empty) begin
                     cmd.wr_en = 1'b1;
                     cmd.wr_new = 1'b1;
                     cmd.wr_loc = WA_ZERO;
                     cmd.count_inc = 1'b1;
                     cmd.pending_set = 1'b1;
                     status_in = ST_ADDED;
                     state_in = S_RESP;
                  end else begin
                     // walk from the tail, shifting entries with equal or later expiry up by one
                     cmd.rd_sel = RA_LAST;
                     cmd.idx_op = IDX_LAST;
                     state_in = S_ADD_CMP;
                  end
               end
               OP_DELETE: begin
                  if (!stat.id_pending) begin
                     status_in = ST_NOT_PENDING;
                     state_in = S_RESP;
                  end else begin
                     cmd.rd_sel = RA_ZERO;
                     cmd.idx_op = IDX_ZERO;
                     found_in = 1'b0;
                     state_in = S_DEL_SCAN;
                  end
               end
               OP_TICK: begin
                  cmd.tick_inc = 1'b1;
                  cmd.rd_sel = RA_ZERO;
                  hold_valid_in = 1'b0;
                  state_in = S_TICK_CHK;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_ADD_CMP: begin
            cmd.wr_en = 1'b1;
            cmd.wr_loc = WA_IDX_INC;
            if (stat.rd_less) begin
               cmd.wr_new = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.pending_set = 1'b1;
               status_in = ST_ADDED;
               state_in = S_RESP;
            end else if (stat.idx_zero) begin
               state_in = S_ADD_LAST;
            end else begin
               cmd.idx_op = IDX_DEC;
               cmd.rd_sel = RA_IDX_DEC;
            end
         end

         S_ADD_LAST: begin
            cmd.wr_en = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wr_loc = WA_ZERO;
            cmd.count_inc = 1'b1;
            cmd.pending_set = 1'b1;
            status_in = ST_ADDED;
            state_in = S_RESP;
         end

         S_DEL_SCAN: begin
            // entries after the match move down by one
            if (found_ff) begin
               cmd.wr_en = 1'b1;
               cmd.wr_loc = WA_IDX_DEC;
            end else if (stat.rd_id_match) begin
               found_in = 1'b1;
            end
            if (stat.idx_last) begin
               cmd.count_dec = 1'b1;
               cmd.pending_clr = 1'b1;
               status_in = ST_DELETED;
               state_in = S_RESP;
            end else begin
               cmd.idx_op = IDX_INC;
               cmd.rd_sel = RA_IDX_INC;
            end
         end

         S_TICK_CHK: begin
            // a fired entry is held until the next head shows whether it is last
            if (due) begin
               if (hold_valid_ff && !stat.out_free) begin
                  cmd.rd_sel = RA_ZERO;
               end else begin
                  if (hold_valid_ff) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_fired = 1'b1;
                     cmd.rsp_status = ST_FIRED;
                     cmd.rsp_last = 1'b0;
                  end
                  cmd.hold_load = 1'b1;
                  cmd.pop = 1'b1;
                  cmd.rd_sel = RA_ONE;
                  hold_valid_in = 1'b1;
               end
            end else begin
               cmd.rd_sel = RA_ZERO;
               if (stat.out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  cmd.rsp_fired = hold_valid_ff;
                  if (hold_valid_ff) begin
                     cmd.rsp_status = ST_FIRED;
                  end else begin
                     cmd.rsp_status = ST_NOTHING;
                  end
                  hold_valid_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_last = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         status_ff     <= ST_ADDED;
         found_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         found_ff      <= found_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/stq_dp.sv -----
`default_nettype none

module stq_dp
   import stq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   input  wire logic    rsp_ready,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int DEPTH = 2 ** AW;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [WORD_W-1:0] expiry;
      logic [ID_W-1:0]   id;
      logic [WORD_W-1:0] payload;
   } entry_type;

   entry_type          mem [DEPTH];
   entry_type          rd_ff;
   entry_type          wr_data;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [AW-1:0]      rd_log, wr_log;

   req_type            req_ff;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [NUM_IDS-1:0] pending_ff, pending_in;
   logic [WORD_W-1:0]  tick_ff, tick_in;
   logic [ID_W-1:0]    hold_id_ff;
   logic [WORD_W-1:0]  hold_pay_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // status toward the controller
   always_comb begin
      stat.op          = req_ff.operation;
      stat.full        = (count_ff == CW'(CAPACITY));
      stat.empty       = (count_ff == '0);
      stat.id_pending  = pending_ff[req_ff.timer_id];
      stat.rd_less     = (rd_ff.expiry < req_ff.expiry_time);
      stat.rd_due      = (rd_ff.expiry <= tick_ff);
      stat.rd_id_match = (rd_ff.id == req_ff.timer_id);
      stat.idx_zero    = (idx_ff == '0);
      stat.idx_last    = (CW'(idx_ff) == count_ff - CW'(1));
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // logical positions are offsets from the head of a circular buffer
   always_comb begin
      case (cmd.rd_sel)
         RA_ZERO:    rd_log = '0;
         RA_ONE:     rd_log = AW'(1);
         RA_LAST:    rd_log = AW'(count_ff - CW'(1));
         RA_IDX_DEC: rd_log = idx_ff - AW'(1);
         RA_IDX_INC: rd_log = idx_ff + AW'(1);
         default:    rd_log = '0;
      endcase
      case (cmd.wr_loc)
         WA_ZERO:    wr_log = '0;
         WA_IDX_INC: wr_log = idx_ff + AW'(1);
         WA_IDX_DEC: wr_log = idx_ff - AW'(1);
         default:    wr_log = '0;
      endcase
      rd_addr = head_ff + rd_log;
      wr_addr = head_ff + wr_log;
      if (cmd.wr_new) begin
         wr_data.expiry  = req_ff.expiry_time;
         wr_data.id      = req_ff.timer_id;
         wr_data.payload = req_ff.payload;
      end else begin
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_ZERO: idx_in = '0;
         IDX_LAST: idx_in = AW'(count_ff - CW'(1));
         IDX_DEC:  idx_in = idx_ff - AW'(1);
         IDX_INC:  idx_in = idx_ff + AW'(1);
         default:  idx_in = idx_ff;
      endcase

      head_in = head_ff;
      count_in = count_ff;
      pending_in = pending_ff;
      if (cmd.pop) begin
         head_in = head_ff + AW'(1);
         count_in = count_ff - CW'(1);
         pending_in[rd_ff.id] = 1'b0;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.pending_set) begin
         pending_in[req_ff.timer_id] = 1'b1;
      end
      if (cmd.pending_clr) begin
         pending_in[req_ff.timer_id] = 1'b0;
      end

      tick_in = cmd.tick_inc ? tick_ff + WORD_W'(1) : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
         tick_ff    <= '0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         tick_ff    <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.hold_load) begin
         hold_id_ff  <= rd_ff.id;
         hold_pay_ff <= rd_ff.payload;
      end
   end

   // result register; a new result loads only when the slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status        <= cmd.rsp_status;
         rsp_ff.fired_id      <= cmd.rsp_fired ? hold_id_ff : '0;
         rsp_ff.fired_payload <= cmd.rsp_fired ? hold_pay_ff : '0;
         rsp_ff.current_tick  <= tick_ff;
         rsp_ff.last          <= cmd.rsp_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- design/sorted_timer_queue_top.sv -----
`default_nettype none

// Sorted timer queue. Pending timers sit in a circular buffer kept in expiry
// order, one memory read and one write per cycle. An add on an empty queue
// writes the head directly; otherwise it walks from the tail, shifting up each
// queued entry whose expiry is equal or later. Rejected adds and deletes go
// straight to the result. A delete walks the whole queue once. A tick pops
// every due timer; fired results carry last=1 only on the final one. Result
// stalls hold up the tick walk and the result state. A new item is taken only
// once the previous one has finished, while its last result may still wait in
// the output register.
module sorted_timer_queue_top
   import stq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   stq_chan_if.sink   req_ch,
   stq_chan_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;
   logic     idle;
   logic     req_fire;
   rsp_type  rsp_data;

   assign req_ch.ready = idle && !reset;
   assign req_fire = req_ch.valid && req_ch.ready;

   stq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .stat     (stat),
      .idle     (idle),
      .cmd      (cmd)
   );

   stq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_ch.payload),
      .cmd       (cmd),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_ch.payload = rsp_data;

endmodule

`default_nettype wire

// ----- tb/sorted_timer_queue_top_test.sv -----
`timescale 1ns / 1ps

module sorted_timer_queue_top_test;
   import stq_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY_DEFAULT;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 100;

   class timer_scoreboard;
      logic [WORD_W-1:0] slot_expiry[QUEUE_DEPTH];
      logic [ID_W-1:0]   slot_id[QUEUE_DEPTH];
      logic [WORD_W-1:0] slot_payload[QUEUE_DEPTH];
      int                slot_count;
      logic [NUM_IDS-1:0] armed_mask;
      logic [WORD_W-1:0] tick_now;
      rsp_type           due_rsp[$];
      int                mismatches;

      function new();
         slot_count = 0;
         armed_mask = '0;
         tick_now = '0;
         mismatches = 0;
      endfunction

      function rsp_type make_rsp(status_type st, logic [ID_W-1:0] id,
                                 logic [WORD_W-1:0] pay, logic last);
         rsp_type r;
         r.status = st;
         r.fired_id = id;
         r.fired_payload = pay;
         r.current_tick = tick_now;
         r.last = last;
         return r;
      endfunction

      function void drop_slot(int pos);
         for (int i = pos; i + 1 < slot_count; i++) begin
            slot_expiry[i] = slot_expiry[i + 1];
            slot_id[i] = slot_id[i + 1];
            slot_payload[i] = slot_payload[i + 1];
         end
         slot_count--;
      endfunction

      // called on every accepted request transfer
      function void note_request(req_type q);
         int pos;
         bit have_held;
         rsp_type held;
         case (q.operation)
            OP_ADD: begin
               if (slot_count >= QUEUE_DEPTH) begin
                  due_rsp.push_back(make_rsp(ST_FULL, '0, '0, 1'b1));
               end else if (armed_mask[q.timer_id]) begin
                  due_rsp.push_back(make_rsp(ST_PENDING, '0, '0, 1'b1));
               end else begin
                  pos = 0;
                  while (pos < slot_count && slot_expiry[pos] < q.expiry_time) pos++;
                  for (int i = slot_count; i > pos; i--) begin
                     slot_expiry[i] = slot_expiry[i - 1];
                     slot_id[i] = slot_id[i - 1];
                     slot_payload[i] = slot_payload[i - 1];
                  end
                  slot_expiry[pos] = q.expiry_time;
                  slot_id[pos] = q.timer_id;
                  slot_payload[pos] = q.payload;
                  slot_count++;
                  armed_mask[q.timer_id] = 1'b1;
                  due_rsp.push_back(make_rsp(ST_ADDED, '0, '0, 1'b1));
               end
            end
            OP_DELETE: begin
               if (!armed_mask[q.timer_id]) begin
                  due_rsp.push_back(make_rsp(ST_NOT_PENDING, '0, '0, 1'b1));
               end else begin
                  pos = 0;
                  while (pos < slot_count && slot_id[pos] != q.timer_id) pos++;
                  if (pos < slot_count) drop_slot(pos);
                  armed_mask[q.timer_id] = 1'b0;
                  due_rsp.push_back(make_rsp(ST_DELETED, '0, '0, 1'b1));
               end
            end
            OP_TICK: begin
               tick_now = tick_now + 1;
               have_held = 1'b0;
               // hold back the newest fired result so its last flag can be set
               while (slot_count > 0 && slot_expiry[0] <= tick_now) begin
                  if (have_held) due_rsp.push_back(held);
                  held = make_rsp(ST_FIRED, slot_id[0], slot_payload[0], 1'b0);
                  have_held = 1'b1;
                  armed_mask[slot_id[0]] = 1'b0;
                  drop_slot(0);
               end
               if (have_held) begin
                  held.last = 1'b1;
                  due_rsp.push_back(held);
               end else begin
                  due_rsp.push_back(make_rsp(ST_NOTHING, '0, '0, 1'b1));
               end
            end
            default: ;
         endcase
      endfunction

      function string show_rsp(rsp_type r);
         return $sformatf("status=%0d id=%0d payload=%h tick=%h last=%0d",
                          r.status, r.fired_id, r.fired_payload, r.current_tick, r.last);
      endfunction

      // called on every accepted result transfer
      function void check_response(rsp_type got);
         rsp_type want;
         if (due_rsp.size() == 0) begin
            if (mismatches < 10) $display("unexpected result: %s", show_rsp(got));
            mismatches++;
            return;
         end
         want = due_rsp.pop_front();
         if (got.status !== want.status || got.fired_id !== want.fired_id ||
             got.fired_payload !== want.fired_payload ||
             got.current_tick !== want.current_tick || got.last !== want.last) begin
            if (mismatches < 10)
               $display("mismatch: expected %s, got %s", show_rsp(want), show_rsp(got));
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   stq_chan_if #(.payload_type(req_type)) req_if ();
   stq_chan_if #(.payload_type(rsp_type)) rsp_if ();

   sorted_timer_queue_top #(
      .CAPACITY(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   timer_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_kick = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: checks result transfers, drives ready, runs the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // valid stays high from one transfer to the next unless a gap is rolled
   task automatic send_req(input req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= q;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(q);
   endtask

   task automatic send_op(input op_type op, input logic [ID_W-1:0] id,
                          input logic [WORD_W-1:0] expiry, input logic [WORD_W-1:0] pay);
      req_type q;
      q.operation = op;
      q.timer_id = id;
      q.expiry_time = expiry;
      q.payload = pay;
      send_req(q);
   endtask

   // mostly expiries close to the current tick so timers actually fire
   function automatic req_type pick_random_req();
      req_type q;
      int roll;
      int k;
      roll = $urandom_range(99);
      q.timer_id = ID_W'($urandom_range(31));
      q.expiry_time = $urandom;
      q.payload = $urandom;
      if (roll < 45) begin
         q.operation = OP_ADD;
         k = $urandom_range(99);
         if (k < 65) q.expiry_time = sb.tick_now + $urandom_range(1, 12);
         else if (k < 80) q.expiry_time = sb.tick_now - $urandom_range(0, 3);
      end else if (roll < 65) begin
         q.operation = OP_DELETE;
         if (sb.armed_mask != '0 && $urandom_range(99) < 75) begin
            do q.timer_id = ID_W'($urandom_range(31)); while (!sb.armed_mask[q.timer_id]);
         end
      end else if (roll < 95) begin
         q.operation = OP_TICK;
      end else begin
         q.operation = OP_NONE;
      end
      return q;
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      send_idle_pct = 34;
      recv_idle_pct = 87;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_op(OP_TICK, 5'd0, 32'h0, 32'h0);           // nothing due
      send_op(OP_DELETE, 5'd0, 32'h0, 32'h0);         // not pending
      send_op(OP_ADD, 5'd0, 32'h0, 32'h0);            // already overdue
      send_op(OP_ADD, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_ADD, 5'd31, 32'h5, 32'h1);           // already pending
      send_op(OP_ADD, 5'd5, 32'h3, 32'hA5A5_A5A5);
      send_op(OP_ADD, 5'd6, 32'h3, 32'h5A5A_5A5A);    // equal expiry goes ahead
      send_op(OP_ADD, 5'd7, 32'h2, 32'h1234_5678);
      send_op(OP_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_TICK, 5'd0, 32'h0, 32'h0);
      send_op(OP_TICK, 5'd0, 32'h0, 32'h0);
      send_op(OP_TICK, 5'd0, 32'h0, 32'h0);
      send_op(OP_DELETE, 5'd31, 32'h0, 32'h0);
      send_op(OP_DELETE, 5'd31, 32'h0, 32'h0);
      send_op(OP_ADD, 5'd3, 32'd10, 32'h0000_0003);
      send_op(OP_ADD, 5'd4, 32'd8, 32'h0000_0004);
      send_op(OP_ADD, 5'd2, 32'd9, 32'h0000_0002);
      send_op(OP_DELETE, 5'd2, 32'h0, 32'h0);         // middle of the queue

      for (int n = 0; n < 60; n++) begin
         if (n == 20) hold_kick <= hold_kick + 1;
         send_req(pick_random_req());
      end

      send_idle_pct = 87;
      recv_idle_pct = 34;
      for (int n = 0; n < 60; n++) send_req(pick_random_req());

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // fill the queue with timers all due on the next tick
      for (int id = 0; id < NUM_IDS; id++) begin
         if (sb.armed_mask[id]) send_op(OP_DELETE, id[ID_W-1:0], 32'h0, 32'h0);
         send_op(OP_ADD, id[ID_W-1:0], sb.tick_now + 1, $urandom);
      end
      send_op(OP_ADD, 5'($urandom_range(31)), $urandom, $urandom);   // full
      send_op(OP_TICK, 5'd0, 32'h0, 32'h0);                          // all fire
      for (int n = 0; n < 20; n++) send_req(pick_random_req());
      req_if.valid <= 1'b0;

      while (sb.due_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
